// ----- hw/rtl/ffha_pkg.sv -----
package ffha_pkg;

   // Default sizes of the allocator.
   localparam int DEF_MAX_BLOCKS   = 64;
   localparam int DEF_REGION_BYTES = 1024;
   localparam int DEF_HEADER_BYTES = 48;

   // Full span of the heap address space in bytes.
   localparam logic [16:0] HEAP_SPAN = 17'h10000;

   // Request operation codes.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REALLOC = 2'd2;
   localparam logic [1:0] OP_RESET   = 2'd3;

   // Response status codes.
   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_NULL    = 3'd1;
   localparam logic [2:0] STS_OOM     = 3'd2;
   localparam logic [2:0] STS_FULL    = 3'd3;
   localparam logic [2:0] STS_UNKNOWN = 3'd4;
   localparam logic [2:0] STS_FREED   = 3'd5;

   // How a request was served.
   localparam logic [2:0] SRV_REUSE  = 3'd0;
   localparam logic [2:0] SRV_SPLIT  = 3'd1;
   localparam logic [2:0] SRV_NEW    = 3'd2;
   localparam logic [2:0] SRV_RESIZE = 3'd3;
   localparam logic [2:0] SRV_FREED  = 3'd4;
   localparam logic [2:0] SRV_NONE   = 3'd5;

   // One heap block as held in a cell.
   typedef struct packed {
      logic        free;
      logic [15:0] used;
      logic [16:0] cap;
   } entry_type;

   // Commands broadcast from the sequencer to all cells.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_WRITE,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_RELEASE,
      CMD_ABSORB
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      entry_type    data;
   } cmd_type;

   // Search key seen by every cell during a scan.
   typedef struct packed {
      logic [15:0] off;
      logic [16:0] asize;
      logic        full;
   } key_type;

   // Scan token that walks the chain one cell per cycle.
   typedef struct packed {
      logic        valid;
      logic [17:0] pos;
      logic        prev_free;
      logic        loc_found;
      logic        loc_free;
      logic [16:0] loc_cap;
      logic        loc_next_done;
      logic        loc_next_free;
      logic        loc_prev_free;
      logic        alloc_found;
      logic        alloc_split;
      logic [17:0] alloc_pos;
      logic [15:0] alloc_used;
      logic [16:0] alloc_cap;
   } token_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_SPLIT_OPEN,
      S_SPLIT_WRITE,
      S_REL1,
      S_REL2,
      S_REL3,
      S_REL4,
      S_REL5,
      S_DONE
   } state_type;

   // Which request step the current scan serves.
   typedef enum logic [2:0] {
      PH_ALLOC,
      PH_FREE,
      PH_RLOC,
      PH_RALLOC,
      PH_RREL
   } phase_type;

endpackage

// ----- hw/rtl/ffha_cell.sv -----
module ffha_cell #(
   parameter int INDEX        = 0,
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 48,
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  ffha_pkg::entry_type left_i,
   input  ffha_pkg::entry_type right_i,
   output ffha_pkg::entry_type entry_o,
   input  ffha_pkg::cmd_type   cmd_i,
   input  logic [IW-1:0]       cmd_idx_i,
   input  ffha_pkg::key_type   key_i,
   input  logic [CW-1:0]       count_i,
   input  ffha_pkg::token_type tok_i,
   input  logic [IW-1:0]       loc_idx_i,
   input  logic [IW-1:0]       alloc_idx_i,
   output ffha_pkg::token_type tok_o,
   output logic [IW-1:0]       loc_idx_o,
   output logic [IW-1:0]       alloc_idx_o
);
   import ffha_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
   localparam logic [17:0]   HDR    = 18'(HEADER_BYTES);

   entry_type     entry_ff, entry_in;
   token_type     tok_ff, tok_in;
   logic [IW-1:0] loc_idx_ff, loc_idx_in;
   logic [IW-1:0] alloc_idx_ff, alloc_idx_in;

   logic        active;
   logic [17:0] data_pos;
   logic [17:0] slack;
   logic [17:0] need;
   logic        reuse_ok;
   logic        split_ok;
   logic        loc_hit;
   logic        alloc_hit;

   // Match logic for the passing scan token.
   always_comb begin
      active    = count_i > CW'(INDEX);
      data_pos  = tok_i.pos + HDR;
      slack     = {1'b0, entry_ff.cap} - {2'b00, entry_ff.used};
      need      = {1'b0, key_i.asize} + HDR;
      reuse_ok  = active && entry_ff.free && (entry_ff.cap >= key_i.asize);
      split_ok  = active && !entry_ff.free && !key_i.full && (slack >= need);
      loc_hit   = tok_i.valid && active && !tok_i.loc_found &&
                  (data_pos == {2'b00, key_i.off});
      alloc_hit = tok_i.valid && !tok_i.alloc_found && (reuse_ok || split_ok);
   end

   // Next token: advance the running offset and record the first hits.
   always_comb begin
      tok_in       = tok_i;
      loc_idx_in   = loc_idx_i;
      alloc_idx_in = alloc_idx_i;
      if (active) begin
         tok_in.pos = tok_i.pos + HDR + {1'b0, entry_ff.cap};
      end
      tok_in.prev_free = active && entry_ff.free;
      if (loc_hit) begin
         tok_in.loc_found     = 1'b1;
         tok_in.loc_free      = entry_ff.free;
         tok_in.loc_cap       = entry_ff.cap;
         tok_in.loc_prev_free = tok_i.prev_free;
         tok_in.loc_next_done = 1'b0;
         tok_in.loc_next_free = 1'b0;
         loc_idx_in           = MY_IDX;
      end else if (tok_i.loc_found && !tok_i.loc_next_done) begin
         tok_in.loc_next_done = 1'b1;
         tok_in.loc_next_free = active && entry_ff.free;
      end
      if (alloc_hit) begin
         tok_in.alloc_found = 1'b1;
         tok_in.alloc_split = !reuse_ok;
         tok_in.alloc_pos   = tok_i.pos;
         tok_in.alloc_used  = entry_ff.used;
         tok_in.alloc_cap   = entry_ff.cap;
         alloc_idx_in       = MY_IDX;
      end
   end

   // Entry update from the broadcast command.
   always_comb begin
      entry_in = entry_ff;
      case (cmd_i.kind)
         CMD_WRITE: begin
            if (cmd_idx_i == MY_IDX) begin
               entry_in = cmd_i.data;
            end
         end
         CMD_OPEN: begin
            if (MY_IDX > cmd_idx_i) begin
               entry_in = left_i;
            end
         end
         CMD_CLOSE: begin
            if (MY_IDX >= cmd_idx_i) begin
               entry_in = right_i;
            end
         end
         CMD_RELEASE: begin
            if (cmd_idx_i == MY_IDX) begin
               entry_in.free = 1'b1;
               entry_in.used = '0;
            end
         end
         CMD_ABSORB: begin
            if (cmd_idx_i == MY_IDX) begin
               entry_in.used = '0;
               entry_in.cap  = 17'(entry_ff.cap + right_i.cap + HDR);
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      loc_idx_ff   <= loc_idx_in;
      alloc_idx_ff <= alloc_idx_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry_o     = entry_ff;
   assign tok_o       = tok_ff;
   assign loc_idx_o   = loc_idx_ff;
   assign alloc_idx_o = alloc_idx_ff;

endmodule

// ----- hw/rtl/ffha_chain.sv -----
module ffha_chain #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 48,
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  ffha_pkg::cmd_type   cmd_i,
   input  logic [IW-1:0]       cmd_idx_i,
   input  ffha_pkg::key_type   key_i,
   input  logic [CW-1:0]       count_i,
   input  logic                start_i,
   output ffha_pkg::token_type tok_o,
   output logic [IW-1:0]       loc_idx_o,
   output logic [IW-1:0]       alloc_idx_o
);
   import ffha_pkg::*;

   entry_type     ent   [MAX_BLOCKS];
   token_type     tok   [MAX_BLOCKS+1];
   logic [IW-1:0] lidx  [MAX_BLOCKS+1];
   logic [IW-1:0] aidx  [MAX_BLOCKS+1];

   // A fresh token enters the first cell with offset zero.
   assign tok[0]  = {start_i, {($bits(token_type) - 1){1'b0}}};
   assign lidx[0] = '0;
   assign aidx[0] = '0;

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      entry_type left_w, right_w;

      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = ent[k-1];
      end
      if (k == MAX_BLOCKS - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = ent[k+1];
      end

      ffha_cell #(
         .INDEX        (k),
         .MAX_BLOCKS   (MAX_BLOCKS),
         .HEADER_BYTES (HEADER_BYTES)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .left_i      (left_w),
         .right_i     (right_w),
         .entry_o     (ent[k]),
         .cmd_i       (cmd_i),
         .cmd_idx_i   (cmd_idx_i),
         .key_i       (key_i),
         .count_i     (count_i),
         .tok_i       (tok[k]),
         .loc_idx_i   (lidx[k]),
         .alloc_idx_i (aidx[k]),
         .tok_o       (tok[k+1]),
         .loc_idx_o   (lidx[k+1]),
         .alloc_idx_o (aidx[k+1])
      );
   end

   assign tok_o       = tok[MAX_BLOCKS];
   assign loc_idx_o   = lidx[MAX_BLOCKS];
   assign alloc_idx_o = aidx[MAX_BLOCKS];

endmodule

// ----- hw/rtl/first_fit_heap_allocator_top.sv -----
// Channel | Direction | Handshake              | Payload
// req     | in        | req_tvalid/req_tready  | operation, size, pointer flag, offset
// rsp     | out       | rsp_tvalid/rsp_tready  | status, result, served_by, heap_top
// csr     | in        | csr_we                 | heap_limit
//
// Requests are handled one at a time. Each pass sends the scan token down the block
// chain and is followed by an evaluation step; alloc and free take one pass, a moving
// realloc takes three. A split then opens a slot and writes it, a release frees the
// block and may absorb and close its next and previous free neighbors, and an output
// step follows. Reset clears the block count and heap end and sets heap_limit to 65536.
// A stalled response holds in the output register while the next request runs.
module first_fit_heap_allocator_top #(
   parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
   parameter int REGION_BYTES = ffha_pkg::DEF_REGION_BYTES,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0], request_size[17:2], has_pointer[18], data_offset[34:19], zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], has_result[3], result_offset[19:4], served_by[22:20], heap_top[39:23]
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);
   import ffha_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BLOCKS);
   localparam logic [18:0]   HDR       = 19'(HEADER_BYTES);
   localparam logic [18:0]   REGION    = 19'(REGION_BYTES);

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [16:0]   limit_ff;
   logic [15:0]   size_ff, size_in;
   logic [15:0]   off_ff, off_in;
   logic [16:0]   asize_ff, asize_in;
   logic [CW-1:0] count_ff, count_in;
   logic [16:0]   heap_end_ff, heap_end_in;
   logic          go_ff, go_in;
   logic [2:0]    sts_ff, sts_in;
   logic          has_ff, has_in;
   logic [15:0]   res_ff, res_in;
   logic [2:0]    how_ff, how_in;
   token_type     tk_ff;
   logic [IW-1:0] tk_lidx_ff, tk_aidx_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;

   cmd_type       cmd;
   logic [IW-1:0] cmd_idx;
   key_type       key;
   token_type     tok_end;
   logic [IW-1:0] end_lidx, end_aidx;

   logic          accept;
   logic [1:0]    req_op;
   logic [15:0]   req_size;
   logic          req_ptr;
   logic [15:0]   req_off;
   logic [18:0]   want;
   logic [18:0]   region;
   logic [18:0]   lim;
   logic          oom;

   assign req_op   = req_tdata[1:0];
   assign req_size = req_tdata[17:2];
   assign req_ptr  = req_tdata[18];
   assign req_off  = req_tdata[34:19];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign key.off   = off_ff;
   assign key.asize = asize_ff;
   assign key.full  = (count_ff >= COUNT_MAX);

   // Growth size and the heap limit check for a new region.
   always_comb begin
      want   = {2'b00, asize_ff} + HDR;
      region = (want < REGION) ? REGION : want;
      lim    = (limit_ff > HEAP_SPAN) ? {2'b00, HEAP_SPAN} : {2'b00, limit_ff};
      oom    = ({2'b00, heap_end_ff} > lim) || (region > lim - {2'b00, heap_end_ff});
   end

   ffha_chain #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .cmd_idx_i   (cmd_idx),
      .key_i       (key),
      .count_i     (count_ff),
      .start_i     (go_ff),
      .tok_o       (tok_end),
      .loc_idx_o   (end_lidx),
      .alloc_idx_o (end_aidx)
   );

   // Request sequencer: scans, table edits and the response.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      asize_in     = asize_ff;
      count_in     = count_ff;
      heap_end_in  = heap_end_ff;
      go_in        = 1'b0;
      sts_in       = sts_ff;
      has_in       = has_ff;
      res_in       = res_ff;
      how_in       = how_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      cmd.kind     = CMD_NONE;
      cmd_idx      = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in  = req_size;
               off_in   = req_off;
               asize_in = {1'b0, req_size};
               sts_in   = STS_OK;
               has_in   = 1'b0;
               res_in   = '0;
               how_in   = SRV_NONE;
               state_in = S_DONE;
               case (req_op)
                  OP_ALLOC: begin
                     if (req_size == '0) begin
                        sts_in = STS_NULL;
                     end else begin
                        phase_in = PH_ALLOC;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_ptr) begin
                        phase_in = PH_FREE;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  OP_REALLOC: begin
                     if (req_size == '0) begin
                        sts_in = STS_NULL;
                     end else if (!req_ptr) begin
                        asize_in = {req_size, 1'b0};
                        phase_in = PH_ALLOC;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        phase_in = PH_RLOC;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     count_in    = '0;
                     heap_end_in = '0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (tok_end.valid) begin
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            case (phase_ff)
               PH_FREE, PH_RREL: begin
                  if (!tk_ff.loc_found) begin
                     sts_in   = STS_UNKNOWN;
                     state_in = S_DONE;
                  end else if (tk_ff.loc_free) begin
                     sts_in   = STS_FREED;
                     state_in = S_DONE;
                  end else begin
                     if (phase_ff == PH_FREE) begin
                        how_in = SRV_FREED;
                     end
                     state_in = S_REL1;
                  end
               end
               PH_RLOC: begin
                  if (!tk_ff.loc_found) begin
                     sts_in   = STS_UNKNOWN;
                     state_in = S_DONE;
                  end else if (tk_ff.loc_free) begin
                     sts_in   = STS_FREED;
                     state_in = S_DONE;
                  end else if (tk_ff.loc_cap >= {1'b0, size_ff}) begin
                     cmd.kind      = CMD_WRITE;
                     cmd.data.free = 1'b0;
                     cmd.data.used = size_ff;
                     cmd.data.cap  = tk_ff.loc_cap;
                     cmd_idx       = tk_lidx_ff;
                     res_in        = off_ff;
                     has_in        = 1'b1;
                     how_in        = SRV_RESIZE;
                     state_in      = S_DONE;
                  end else begin
                     phase_in = PH_RALLOC;
                     go_in    = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (tk_ff.alloc_found && !tk_ff.alloc_split) begin
                     cmd.kind      = CMD_WRITE;
                     cmd.data.free = 1'b0;
                     cmd.data.used = asize_ff[15:0];
                     cmd.data.cap  = tk_ff.alloc_cap;
                     cmd_idx       = tk_aidx_ff;
                     res_in        = 16'(tk_ff.alloc_pos + HDR[17:0]);
                     has_in        = 1'b1;
                     how_in        = SRV_REUSE;
                     if (phase_ff == PH_RALLOC) begin
                        phase_in = PH_RREL;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end else if (tk_ff.alloc_found) begin
                     cmd.kind      = CMD_WRITE;
                     cmd.data.free = 1'b0;
                     cmd.data.used = tk_ff.alloc_used;
                     cmd.data.cap  = {1'b0, tk_ff.alloc_used};
                     cmd_idx       = tk_aidx_ff;
                     res_in        = 16'(tk_ff.alloc_pos + HDR[17:0] +
                                         {2'b00, tk_ff.alloc_used} + HDR[17:0]);
                     has_in        = 1'b1;
                     how_in        = SRV_SPLIT;
                     state_in      = S_SPLIT_OPEN;
                  end else if (count_ff >= COUNT_MAX) begin
                     sts_in   = STS_FULL;
                     state_in = S_DONE;
                  end else if (oom) begin
                     sts_in   = STS_OOM;
                     state_in = S_DONE;
                  end else begin
                     cmd.kind      = CMD_WRITE;
                     cmd.data.free = 1'b0;
                     cmd.data.used = asize_ff[15:0];
                     cmd.data.cap  = 17'(region - HDR);
                     cmd_idx       = count_ff[IW-1:0];
                     count_in      = count_ff + 1'b1;
                     heap_end_in   = 17'({2'b00, heap_end_ff} + region);
                     res_in        = 16'({2'b00, heap_end_ff} + HDR);
                     has_in        = 1'b1;
                     how_in        = SRV_NEW;
                     if (phase_ff == PH_RALLOC) begin
                        phase_in = PH_RREL;
                        go_in    = 1'b1;
                        state_in = S_SCAN;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               end
            endcase
         end

         // Split: make room after the trimmed block, then fill the new slot.
         S_SPLIT_OPEN: begin
            cmd.kind = CMD_OPEN;
            cmd_idx  = IW'(tk_aidx_ff + 1'b1);
            count_in = count_ff + 1'b1;
            state_in = S_SPLIT_WRITE;
         end

         S_SPLIT_WRITE: begin
            cmd.kind      = CMD_WRITE;
            cmd.data.free = 1'b0;
            cmd.data.used = asize_ff[15:0];
            cmd.data.cap  = 17'({1'b0, tk_ff.alloc_cap} - {2'b00, tk_ff.alloc_used} -
                                HDR[17:0]);
            cmd_idx       = IW'(tk_aidx_ff + 1'b1);
            if (phase_ff == PH_RALLOC) begin
               phase_in = PH_RREL;
               go_in    = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end

         // Release and merge with free neighbors.
         S_REL1: begin
            cmd.kind = CMD_RELEASE;
            cmd_idx  = tk_lidx_ff;
            state_in = S_REL2;
         end

         S_REL2: begin
            if (tk_ff.loc_next_free) begin
               cmd.kind = CMD_ABSORB;
               cmd_idx  = tk_lidx_ff;
               state_in = S_REL3;
            end else begin
               state_in = S_REL4;
            end
         end

         S_REL3: begin
            cmd.kind = CMD_CLOSE;
            cmd_idx  = IW'(tk_lidx_ff + 1'b1);
            count_in = count_ff - 1'b1;
            state_in = S_REL4;
         end

         S_REL4: begin
            if (tk_ff.loc_prev_free) begin
               cmd.kind = CMD_ABSORB;
               cmd_idx  = IW'(tk_lidx_ff - 1'b1);
               state_in = S_REL5;
            end else begin
               state_in = S_DONE;
            end
         end

         S_REL5: begin
            cmd.kind = CMD_CLOSE;
            cmd_idx  = tk_lidx_ff;
            count_in = count_ff - 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {heap_end_ff, how_ff, (has_ff ? res_ff : 16'h0000),
                               has_ff, sts_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ALLOC;
         count_ff     <= '0;
         heap_end_ff  <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= HEAP_SPAN;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         heap_end_ff  <= heap_end_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      off_ff      <= off_in;
      asize_ff    <= asize_in;
      sts_ff      <= sts_in;
      has_ff      <= has_in;
      res_ff      <= res_in;
      how_ff      <= how_in;
      rsp_data_ff <= rsp_data_in;
      if (tok_end.valid) begin
         tk_ff      <= tok_end;
         tk_lidx_ff <= end_lidx;
         tk_aidx_ff <= end_aidx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("block count above table depth");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_end.valid |-> state_ff == S_SCAN)
      else $error("scan token arrived outside a scan");

   a_null_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[3] || rsp_data_ff[19:4] == 16'h0000))
      else $error("response offset set without a result");
`endif

endmodule

// ----- verif/tb_first_fit_heap_allocator_top.sv -----
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;
   import ffha_pkg::*;

   localparam int NBLK = 64;
   localparam int REGB = 1024;
   localparam int HDRB = 48;
   localparam int WATCH_LIMIT = 200000;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] size;
      logic        has_ptr;
      logic [15:0] ptr;
   } alloc_req_t;

   typedef struct packed {
      logic [2:0]  status;
      logic        has_res;
      logic [15:0] res;
      logic [2:0]  how;
      logic [16:0] top;
   } alloc_rsp_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic [16:0] csr_wdata;

   first_fit_heap_allocator_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Shadow heap table of the allocator.
   logic        sh_free [NBLK];
   int unsigned sh_used [NBLK];
   int unsigned sh_cap  [NBLK];
   int unsigned sh_count;
   int unsigned sh_end;
   int unsigned sh_limit;

   alloc_rsp_t  pending_rsp [$];
   int unsigned live_ptrs [$];
   int          errors;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int find_block(int unsigned off);
      int unsigned pos;
      pos = 0;
      for (int i = 0; i < sh_count; i++) begin
         if (pos + HDRB == off) return i;
         pos += HDRB + sh_cap[i];
      end
      return -1;
   endfunction

   function automatic int unsigned block_data(int unsigned idx);
      int unsigned pos;
      pos = 0;
      for (int i = 0; i < idx; i++) pos += HDRB + sh_cap[i];
      return pos + HDRB;
   endfunction

   function automatic void shift_up(int unsigned at);
      for (int i = sh_count; i > at; i--) begin
         sh_free[i] = sh_free[i-1];
         sh_used[i] = sh_used[i-1];
         sh_cap[i]  = sh_cap[i-1];
      end
      sh_count++;
   endfunction

   function automatic void shift_down(int unsigned at);
      for (int i = at; i + 1 < sh_count; i++) begin
         sh_free[i] = sh_free[i+1];
         sh_used[i] = sh_used[i+1];
         sh_cap[i]  = sh_cap[i+1];
      end
      sh_count--;
   endfunction

   // First-fit search, split of slack, or growth at the heap end.
   function automatic logic [2:0] carve(int unsigned size, output int unsigned off,
                                        output logic [2:0] how);
      int unsigned region, lim, slack, n;
      off = 0;
      how = SRV_NONE;
      for (int i = 0; i < sh_count; i++) begin
         if (sh_free[i] && sh_cap[i] >= size) begin
            sh_free[i] = 1'b0;
            sh_used[i] = size;
            off = block_data(i);
            how = SRV_REUSE;
            return STS_OK;
         end
         if (!sh_free[i] && sh_count < NBLK && sh_cap[i] - sh_used[i] >= size + HDRB) begin
            slack = sh_cap[i] - sh_used[i];
            shift_up(i + 1);
            sh_cap[i] = sh_used[i];
            sh_free[i+1] = 1'b0;
            sh_used[i+1] = size;
            sh_cap[i+1] = slack - HDRB;
            off = block_data(i + 1);
            how = SRV_SPLIT;
            return STS_OK;
         end
      end
      if (sh_count >= NBLK) return STS_FULL;
      region = size + HDRB;
      if (region < REGB) region = REGB;
      lim = sh_limit > 65536 ? 65536 : sh_limit;
      if (sh_end > lim || region > lim - sh_end) return STS_OOM;
      n = sh_count;
      sh_count++;
      sh_free[n] = 1'b0;
      sh_used[n] = size;
      sh_cap[n] = region - HDRB;
      off = sh_end + HDRB;
      sh_end += region;
      how = SRV_NEW;
      return STS_OK;
   endfunction

   function automatic void release_block(int unsigned idx);
      sh_free[idx] = 1'b1;
      sh_used[idx] = 0;
      if (idx + 1 < sh_count && sh_free[idx+1]) begin
         sh_cap[idx] += sh_cap[idx+1] + HDRB;
         shift_down(idx + 1);
      end
      if (idx > 0 && sh_free[idx-1]) begin
         sh_cap[idx-1] += sh_cap[idx] + HDRB;
         sh_used[idx-1] = 0;
         shift_down(idx);
      end
   endfunction

   // Predicts the response of one request and updates the shadow table.
   function automatic alloc_rsp_t predict_alloc(alloc_req_t rq);
      alloc_rsp_t  r;
      int          idx;
      int unsigned off;
      logic [2:0]  how;
      r = '0;
      r.how = SRV_NONE;
      off = 0;
      case (rq.op)
         OP_ALLOC: begin
            if (rq.size == 0) r.status = STS_NULL;
            else begin
               r.status = carve(rq.size, off, how);
               if (r.status == STS_OK) begin r.has_res = 1'b1; r.how = how; end
            end
         end
         OP_FREE: begin
            if (rq.has_ptr) begin
               idx = find_block(rq.ptr);
               if (idx < 0) r.status = STS_UNKNOWN;
               else if (sh_free[idx]) r.status = STS_FREED;
               else begin release_block(idx); r.how = SRV_FREED; end
            end
         end
         OP_REALLOC: begin
            if (rq.size == 0) r.status = STS_NULL;
            else if (!rq.has_ptr) begin
               r.status = carve(rq.size * 2, off, how);
               if (r.status == STS_OK) begin r.has_res = 1'b1; r.how = how; end
            end else begin
               idx = find_block(rq.ptr);
               if (idx < 0) r.status = STS_UNKNOWN;
               else if (sh_free[idx]) r.status = STS_FREED;
               else if (sh_cap[idx] >= rq.size) begin
                  sh_used[idx] = rq.size;
                  off = rq.ptr;
                  r.has_res = 1'b1;
                  r.how = SRV_RESIZE;
               end else begin
                  r.status = carve(rq.size, off, how);
                  if (r.status == STS_OK) begin
                     idx = find_block(rq.ptr);
                     if (idx >= 0) release_block(idx);
                     r.has_res = 1'b1;
                     r.how = how;
                  end
               end
            end
         end
         default: begin
            sh_count = 0;
            sh_end = 0;
         end
      endcase
      r.res = r.has_res ? off[15:0] : 16'd0;
      r.top = sh_end[16:0];
      if (r.has_res) live_ptrs.push_back(off);
      return r;
   endfunction

   // Sends one request; the prediction is made when it is accepted.
   task automatic send_req(alloc_req_t rq);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {5'd0, rq.ptr, rq.has_ptr, rq.size, rq.op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rsp.push_back(predict_alloc(rq));
   endtask

   task automatic expect_req(alloc_req_t rq, alloc_rsp_t ex);
      alloc_rsp_t p;
      send_req(rq);
      p = pending_rsp[$];
      if (p !== ex) begin
         $error("directed prediction expected %h got %h", ex, p);
         errors++;
      end
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8 * NBLK) @(posedge clock);
   endtask

   task automatic set_limit(int unsigned v);
      drain_wait();
      csr_we <= 1'b1;
      csr_wdata <= v[16:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sh_limit = v;
   endtask

   // Picks a pointer: mostly one returned earlier, sometimes arbitrary.
   function automatic int unsigned pick_ptr();
      int unsigned k;
      if (live_ptrs.size() > 0 && $urandom_range(9) < 8) begin
         k = $urandom_range(live_ptrs.size() - 1);
         return live_ptrs[k];
      end
      return $urandom_range(65535);
   endfunction

   function automatic alloc_req_t random_req();
      alloc_req_t rq;
      int unsigned pick;
      rq.op = 2'($urandom_range(3));
      if (rq.op == OP_RESET && $urandom_range(9) != 0) rq.op = OP_FREE;
      pick = $urandom_range(19);
      if (pick < 14) rq.size = 16'($urandom_range(1, 600));
      else if (pick < 17) rq.size = 16'($urandom_range(1, 4000));
      else if (pick < 19) rq.size = 16'($urandom_range(65535));
      else rq.size = 16'd0;
      rq.has_ptr = ($urandom_range(9) != 0);
      rq.ptr = 16'(pick_ptr());
      if ($urandom_range(15) == 0) rq.ptr = 16'($urandom_range(65535));
      return rq;
   endfunction

   // Receiver: random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      alloc_rsp_t got, ex;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = rsp_tdata[2:0];
         got.has_res = rsp_tdata[3];
         got.res     = rsp_tdata[19:4];
         got.how     = rsp_tdata[22:20];
         got.top     = rsp_tdata[39:23];
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            ex = pending_rsp.pop_front();
            if (got.status !== ex.status) begin
               $error("status expected %0d actual %0d", ex.status, got.status); errors++;
            end
            if (got.has_res !== ex.has_res) begin
               $error("has_result expected %0d actual %0d", ex.has_res, got.has_res); errors++;
            end
            if (got.res !== ex.res) begin
               $error("result_offset expected %0d actual %0d", ex.res, got.res); errors++;
            end
            if (got.how !== ex.how) begin
               $error("served_by expected %0d actual %0d", ex.how, got.how); errors++;
            end
            if (got.top !== ex.top) begin
               $error("heap_top expected %0d actual %0d", ex.top, got.top); errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   typedef struct {
      alloc_req_t rq;
      logic       chk;
      alloc_rsp_t ex;
   } dir_row_t;

   dir_row_t dir_rows [$];

   function automatic dir_row_t row(logic [1:0] op, int unsigned size, logic hp,
                                    int unsigned ptr, logic chk, alloc_rsp_t ex);
      dir_row_t d;
      d.rq = '{op: op, size: size[15:0], has_ptr: hp, ptr: ptr[15:0]};
      d.chk = chk;
      d.ex = ex;
      return d;
   endfunction

   initial begin
      alloc_req_t rq;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      sh_count = 0;
      sh_end = 0;
      sh_limit = 65536;
      for (int i = 0; i < NBLK; i++) begin
         sh_free[i] = 1'b0; sh_used[i] = 0; sh_cap[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty heap cases, first region, split, merge, extremes.
      dir_rows.push_back(row(OP_ALLOC, 0, 0, 0, 1,
                             '{STS_NULL, 1'b0, 16'd0, SRV_NONE, 17'd0}));
      dir_rows.push_back(row(OP_FREE, 0, 0, 0, 1,
                             '{STS_OK, 1'b0, 16'd0, SRV_NONE, 17'd0}));
      dir_rows.push_back(row(OP_FREE, 0, 1, 48, 1,
                             '{STS_UNKNOWN, 1'b0, 16'd0, SRV_NONE, 17'd0}));
      dir_rows.push_back(row(OP_ALLOC, 100, 0, 0, 1,
                             '{STS_OK, 1'b1, 16'd48, SRV_NEW, 17'd1024}));
      dir_rows.push_back(row(OP_ALLOC, 200, 0, 0, 0, '0));
      dir_rows.push_back(row(OP_ALLOC, 65535, 0, 0, 1,
                             '{STS_OOM, 1'b0, 16'd0, SRV_NONE, 17'd1024}));
      dir_rows.push_back(row(OP_REALLOC, 0, 1, 48, 1,
                             '{STS_NULL, 1'b0, 16'd0, SRV_NONE, 17'd1024}));
      dir_rows.push_back(row(OP_REALLOC, 50, 1, 48, 0, '0));
      dir_rows.push_back(row(OP_REALLOC, 900, 1, 48, 0, '0));
      dir_rows.push_back(row(OP_REALLOC, 300, 0, 0, 0, '0));
      dir_rows.push_back(row(OP_FREE, 0, 1, 48, 0, '0));
      dir_rows.push_back(row(OP_FREE, 0, 1, 48, 0, '0));
      dir_rows.push_back(row(OP_REALLOC, 10, 1, 48, 0, '0));
      dir_rows.push_back(row(OP_FREE, 0, 1, 65535, 0, '0));
      dir_rows.push_back(row(OP_ALLOC, 65487, 0, 0, 0, '0));
      dir_rows.push_back(row(OP_ALLOC, 1, 0, 0, 0, '0));
      dir_rows.push_back(row(OP_RESET, 0, 0, 0, 1,
                             '{STS_OK, 1'b0, 16'd0, SRV_NONE, 17'd0}));
      dir_rows.push_back(row(OP_ALLOC, 65488, 0, 0, 1,
                             '{STS_OK, 1'b1, 16'd48, SRV_NEW, 17'd65536}));
      dir_rows.push_back(row(OP_ALLOC, 1, 0, 0, 1,
                             '{STS_OOM, 1'b0, 16'd0, SRV_NONE, 17'd65536}));
      dir_rows.push_back(row(OP_RESET, 0, 0, 0, 0, '0));
      foreach (dir_rows[i]) begin
         if (dir_rows[i].chk) expect_req(dir_rows[i].rq, dir_rows[i].ex);
         else send_req(dir_rows[i].rq);
      end

      // Fill the table with small allocations to reach the full-table case.
      for (int i = 0; i < 70; i++) begin
         rq = '{op: OP_ALLOC, size: 16'd976, has_ptr: 1'b0, ptr: 16'd0};
         send_req(rq);
      end
      rq = '{op: OP_RESET, size: 16'd0, has_ptr: 1'b0, ptr: 16'd0};
      send_req(rq);
      live_ptrs.delete();

      // Random phases over several heap limits and idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_limit(65536);
            1: set_limit(0);
            2: set_limit(8192);
            3: set_limit(131071);
            4: set_limit(20000);
            default: set_limit(65535);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 59; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 59; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (ph == 0) hold_off = 3000;
         for (int i = 0; i < 160; i++) begin
            rq = random_req();
            if (rq.op == OP_RESET) live_ptrs.delete();
            send_req(rq);
         end
      end

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8 * NBLK) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
